FILE: hdl/grid_dda_dual_hit_ray_caster_assert.svh
// Assertion helpers; clk and rst_n are taken from the enclosing module.
`ifndef GRID_DDA_DUAL_HIT_RAY_CASTER_ASSERT_SVH
`define GRID_DDA_DUAL_HIT_RAY_CASTER_ASSERT_SVH

// same-cycle implication
`define GDDA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define GDDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/gdda_pkg.sv
`default_nettype none

package gdda_pkg;

    localparam logic [1:0] CFG_BLOCKING_MASK   = 2'd0;
    localparam logic [1:0] CFG_PROJECTILE_MASK = 2'd1;
    localparam logic [1:0] CFG_CELL_SIZE       = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CAST  = 1'b1;

    localparam int DELTA_W = 41;
    localparam int QUO_W   = 31;
    localparam logic [9:0] CELL_SIZE_RESET = 10'd32;

    typedef struct packed {
        logic                 func;
        logic [5:0]           cell_x;
        logic [5:0]           cell_y;
        logic [15:0]          cell_mask;
        logic [5:0]           gx;
        logic [5:0]           gy;
        logic                 neg_x;
        logic                 neg_y;
        logic [DELTA_W-1:0]   dx;
        logic [DELTA_W-1:0]   dy;
        logic [DELTA_W-1:0]   tx;
        logic [DELTA_W-1:0]   ty;
    } job_t;

    typedef struct packed {
        logic [15:0] blocking_mask;
        logic [15:0] projectile_mask;
        logic [9:0]  cell_size;
    } cfg_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_MULX,
        F_MULY,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_WALK,
        B_MULP,
        B_MULB
    } back_state_t;

    // t in Q.16 grid units, hi set when t has bits above bit 31
    function automatic logic [23:0] world_dist(logic [31:0] t, logic hi, logic [9:0] cs);
        logic [41:0] prod;
        prod = {10'b0, t} * {32'b0, cs};
        if (hi && (cs != 10'd0))
            return 24'hFFFFFF;
        else if (|prod[41:32])
            return 24'hFFFFFF;
        else
            return prod[31:8];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/grid_dda_dual_hit_ray_caster.sv
`default_nettype none

// Grid ray caster. After reset all 2**(clog2(MAP_WIDTH)+clog2(MAP_HEIGHT)) map
// entries (4096 at 64x64) are swept to zero, one cell a cycle; full stays high
// meanwhile. A cell write passes the front's push state; the walker writes it on
// pop. A cast passes the 31-bit restoring divide for the per-axis step, the x and y
// multiply states and the queue push; the walker pops it, steps one cell per cycle,
// one map read each (a start outside the map skips the walk), scales both distances
// and delivers once the output is free. Front and walker overlap through a
// two-entry queue, so the sustained rate is set by the slower of the two.
module grid_dda_dual_hit_ray_caster #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic                push,
    output logic                     full,
    input  wire logic                func,
    input  wire logic [5:0]          cell_x,
    input  wire logic [5:0]          cell_y,
    input  wire logic [15:0]         cell_mask,
    input  wire logic [15:0]         start_x,
    input  wire logic [15:0]         start_y,
    input  wire logic signed [15:0]  dir_x,
    input  wire logic signed [15:0]  dir_y,
    output logic                     empty,
    input  wire logic                pop,
    output logic                     blocker_found,
    output logic [23:0]              blocker_dist,
    output logic [15:0]              blocker_mask,
    output logic                     projectile_found,
    output logic [23:0]              projectile_dist
);

    gdda_pkg::cfg_t cfg_reg;
    gdda_pkg::job_t f_data, b_data;
    logic           f_push, q_full, q_empty, q_pop, clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blocking_mask   <= '0;
            cfg_reg.projectile_mask <= '0;
            cfg_reg.cell_size       <= gdda_pkg::CELL_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gdda_pkg::CFG_BLOCKING_MASK:   cfg_reg.blocking_mask   <= cfg_data;
                gdda_pkg::CFG_PROJECTILE_MASK: cfg_reg.projectile_mask <= cfg_data;
                gdda_pkg::CFG_CELL_SIZE:       cfg_reg.cell_size       <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    gdda_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (clearing),
        .push      (push),
        .full      (full),
        .func      (func),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .cell_mask (cell_mask),
        .start_x   (start_x),
        .start_y   (start_y),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .q_push    (f_push),
        .q_full    (q_full),
        .q_data    (f_data)
    );

    gdda_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_push),
        .wr_data (f_data),
        .full    (q_full),
        .rd      (q_pop),
        .rd_data (b_data),
        .empty   (q_empty)
    );

    gdda_back #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .clearing         (clearing),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .q_data           (b_data),
        .empty            (empty),
        .pop              (pop),
        .blocker_found    (blocker_found),
        .blocker_dist     (blocker_dist),
        .blocker_mask     (blocker_mask),
        .projectile_found (projectile_found),
        .projectile_dist  (projectile_dist)
    );

endmodule

`default_nettype wire

FILE: hdl/gdda_front.sv
`default_nettype none

module gdda_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                hold,
    input  wire logic                push,
    output logic                     full,
    input  wire logic                func,
    input  wire logic [5:0]          cell_x,
    input  wire logic [5:0]          cell_y,
    input  wire logic [15:0]         cell_mask,
    input  wire logic [15:0]         start_x,
    input  wire logic [15:0]         start_y,
    input  wire logic signed [15:0]  dir_x,
    input  wire logic signed [15:0]  dir_y,
    output logic                     q_push,
    input  wire logic                q_full,
    output gdda_pkg::job_t           q_data
);

    gdda_pkg::front_state_t state_reg, state_next;

    gdda_pkg::job_t                  job_reg;
    logic [9:0]                      fx_reg, fy_reg;
    logic [15:0]                     magx_reg, magy_reg;
    logic [15:0]                     remx_reg, remy_reg;
    logic [gdda_pkg::QUO_W-1:0]      qx_reg, qy_reg;
    logic [4:0]                      cnt_reg;

    logic        accept;
    logic        lead;
    logic [16:0] rx, ry;
    logic        gex, gey;
    logic [15:0] vx, vy;
    logic [10:0] fxm, fym;
    logic [41:0] prodx, prody;

    assign full   = (state_reg != gdda_pkg::F_IDLE) || hold;
    assign accept = push && !full;
    assign q_data = job_reg;

    assign lead = (cnt_reg == 5'd30);
    assign rx   = {remx_reg, lead};
    assign ry   = {remy_reg, lead};
    assign gex  = rx >= {1'b0, magx_reg};
    assign gey  = ry >= {1'b0, magy_reg};

    assign vx = dir_x;
    assign vy = dir_y;

    assign fxm   = job_reg.neg_x ? {1'b0, fx_reg} : 11'd1024 - {1'b0, fx_reg};
    assign fym   = job_reg.neg_y ? {1'b0, fy_reg} : 11'd1024 - {1'b0, fy_reg};
    assign prodx = {31'b0, fxm} * {11'b0, qx_reg};
    assign prody = {31'b0, fym} * {11'b0, qy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gdda_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        q_push     = 1'b0;
        unique case (state_reg)
            gdda_pkg::F_IDLE:
            begin
                if (accept)
                    state_next = (func == gdda_pkg::FUNC_CAST) ? gdda_pkg::F_DIV
                                                               : gdda_pkg::F_PUSH;
            end
            gdda_pkg::F_DIV:
            begin
                if (cnt_reg == 5'd0)
                    state_next = gdda_pkg::F_MULX;
            end
            gdda_pkg::F_MULX:
                state_next = gdda_pkg::F_MULY;
            gdda_pkg::F_MULY:
                state_next = gdda_pkg::F_PUSH;
            gdda_pkg::F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = gdda_pkg::F_IDLE;
                end
            end
            default:
                state_next = gdda_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            gdda_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    job_reg.func      <= func;
                    job_reg.cell_x    <= cell_x;
                    job_reg.cell_y    <= cell_y;
                    job_reg.cell_mask <= cell_mask;
                    job_reg.gx        <= start_x[15:10];
                    job_reg.gy        <= start_y[15:10];
                    job_reg.neg_x     <= vx[15];
                    job_reg.neg_y     <= vy[15];
                    fx_reg            <= start_x[9:0];
                    fy_reg            <= start_y[9:0];
                    magx_reg          <= vx[15] ? 16'(16'd0 - vx) : vx;
                    magy_reg          <= vy[15] ? 16'(16'd0 - vy) : vy;
                    remx_reg          <= '0;
                    remy_reg          <= '0;
                    qx_reg            <= '0;
                    qy_reg            <= '0;
                    cnt_reg           <= 5'd30;
                end
            end
            gdda_pkg::F_DIV:
            begin
                remx_reg <= gex ? 16'(rx - {1'b0, magx_reg}) : rx[15:0];
                remy_reg <= gey ? 16'(ry - {1'b0, magy_reg}) : ry[15:0];
                qx_reg   <= {qx_reg[gdda_pkg::QUO_W-2:0], gex};
                qy_reg   <= {qy_reg[gdda_pkg::QUO_W-2:0], gey};
                cnt_reg  <= cnt_reg - 5'd1;
            end
            gdda_pkg::F_MULX:
            begin
                if (magx_reg == 16'd0)
                begin
                    job_reg.dx <= {1'b1, 40'b0};
                    job_reg.tx <= {fxm, 30'b0};
                end
                else
                begin
                    job_reg.dx <= {10'b0, qx_reg};
                    job_reg.tx <= {9'b0, prodx[41:10]};
                end
            end
            gdda_pkg::F_MULY:
            begin
                if (magy_reg == 16'd0)
                begin
                    job_reg.dy <= {1'b1, 40'b0};
                    job_reg.ty <= {fym, 30'b0};
                end
                else
                begin
                    job_reg.dy <= {10'b0, qy_reg};
                    job_reg.ty <= {9'b0, prody[41:10]};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/gdda_fifo.sv
`default_nettype none

module gdda_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr,
    input  wire gdda_pkg::job_t  wr_data,
    output logic                 full,
    input  wire logic            rd,
    output gdda_pkg::job_t       rd_data,
    output logic                 empty
);

    localparam int DEPTH = 2;

    gdda_pkg::job_t slot_reg [DEPTH];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full    = (count_reg == 2'(DEPTH));
    assign empty   = (count_reg == 2'd0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr && !full)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd && !empty)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr && !full)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

FILE: hdl/gdda_back.sv
`default_nettype none

module gdda_back #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire gdda_pkg::cfg_t  cfg,
    output logic                 clearing,
    input  wire logic            q_empty,
    output logic                 q_pop,
    input  wire gdda_pkg::job_t  q_data,
    output logic                 empty,
    input  wire logic            pop,
    output logic                 blocker_found,
    output logic [23:0]          blocker_dist,
    output logic [15:0]          blocker_mask,
    output logic                 projectile_found,
    output logic [23:0]          projectile_dist
);

    `include "grid_dda_dual_hit_ray_caster_assert.svh"

    localparam int XW    = $clog2(MAP_WIDTH);
    localparam int YW    = $clog2(MAP_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int PXW   = ((XW > 6) ? XW : 6) + 2;
    localparam int PYW   = ((YW > 6) ? YW : 6) + 2;
    localparam int T_W   = gdda_pkg::DELTA_W + $clog2(MAP_WIDTH + MAP_HEIGHT + 2) + 1;

    gdda_pkg::back_state_t state_reg, state_next;

    logic [15:0]  mem [DEPTH];
    logic [15:0]  mem_q;
    logic         mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]  mem_wdata;

    logic [AW:0]  clr_cnt_reg;

    logic signed [PXW-1:0] gx_reg;
    logic signed [PYW-1:0] gy_reg;
    logic [T_W-1:0]        tx_reg, ty_reg, pend_t_reg, pt_reg, bt_reg;
    logic [gdda_pkg::DELTA_W-1:0] dx_reg, dy_reg;
    logic         negx_reg, negy_reg;
    logic         pend_reg, prj_reg, blk_reg;
    logic [15:0]  bmask_reg;
    logic [23:0]  pdist_reg;

    logic         out_valid_reg;
    logic         res_blk_reg, res_prj_reg;
    logic [23:0]  res_bdist_reg, res_pdist_reg;
    logic [15:0]  res_bmask_reg;

    logic         hit_b, hit_p, take_x, out_of_map, in_map, out_free, res_load, cell_ok;
    logic signed [PXW-1:0] ngx;
    logic signed [PYW-1:0] ngy;
    logic [T_W-1:0] nt;
    logic [T_W-1:0] wt;
    logic [23:0]  wd;

    assign clearing = (state_reg == gdda_pkg::B_CLEAR);
    assign empty    = !out_valid_reg;
    assign out_free = !out_valid_reg || pop;

    assign blocker_found    = res_blk_reg;
    assign blocker_dist     = res_bdist_reg;
    assign blocker_mask     = res_bmask_reg;
    assign projectile_found = res_prj_reg;
    assign projectile_dist  = res_pdist_reg;

    assign hit_b  = pend_reg && |(mem_q & cfg.blocking_mask);
    assign hit_p  = pend_reg && |(mem_q & cfg.projectile_mask);
    assign take_x = tx_reg < ty_reg;
    assign ngx    = take_x ? (gx_reg + (negx_reg ? -PXW'(1) : PXW'(1))) : gx_reg;
    assign ngy    = take_x ? gy_reg : (gy_reg + (negy_reg ? -PYW'(1) : PYW'(1)));
    assign nt     = take_x ? tx_reg : ty_reg;
    assign out_of_map = (ngx < 0) || (ngx >= MAP_WIDTH) || (ngy < 0) || (ngy >= MAP_HEIGHT);
    assign in_map = (int'(q_data.gx) < MAP_WIDTH) && (int'(q_data.gy) < MAP_HEIGHT);
    assign cell_ok = (int'(q_data.cell_x) < MAP_WIDTH) && (int'(q_data.cell_y) < MAP_HEIGHT);

    assign mem_raddr = {ngy[YW-1:0], ngx[XW-1:0]};

    assign wt = (state_reg == gdda_pkg::B_MULP) ? pt_reg : bt_reg;
    assign wd = gdda_pkg::world_dist(wt[31:0], |wt[T_W-1:32], cfg.cell_size);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = {YW'(q_data.cell_y), XW'(q_data.cell_x)};
        mem_wdata  = q_data.cell_mask;
        res_load   = 1'b0;
        unique case (state_reg)
            gdda_pkg::B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg[AW-1:0];
                mem_wdata = '0;
                if (clr_cnt_reg == (AW+1)'(DEPTH - 1))
                    state_next = gdda_pkg::B_IDLE;
            end
            gdda_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_data.func == gdda_pkg::FUNC_WRITE)
                        mem_we = cell_ok;
                    else
                        state_next = in_map ? gdda_pkg::B_WALK : gdda_pkg::B_MULP;
                end
            end
            gdda_pkg::B_WALK:
            begin
                if (hit_b || out_of_map)
                    state_next = gdda_pkg::B_MULP;
            end
            gdda_pkg::B_MULP:
                state_next = gdda_pkg::B_MULB;
            gdda_pkg::B_MULB:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = gdda_pkg::B_IDLE;
                end
            end
            default:
                state_next = gdda_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gdda_pkg::B_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gdda_pkg::B_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + (AW+1)'(1);
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            gdda_pkg::B_IDLE:
            begin
                gx_reg    <= PXW'(q_data.gx);
                gy_reg    <= PYW'(q_data.gy);
                tx_reg    <= T_W'(q_data.tx);
                ty_reg    <= T_W'(q_data.ty);
                dx_reg    <= q_data.dx;
                dy_reg    <= q_data.dy;
                negx_reg  <= q_data.neg_x;
                negy_reg  <= q_data.neg_y;
                pend_reg  <= 1'b0;
                prj_reg   <= 1'b0;
                blk_reg   <= 1'b0;
                pt_reg    <= '0;
                bt_reg    <= '0;
                bmask_reg <= '0;
            end
            gdda_pkg::B_WALK:
            begin
                if (hit_p && !prj_reg)
                begin
                    prj_reg <= 1'b1;
                    pt_reg  <= pend_t_reg;
                end
                if (hit_b)
                begin
                    blk_reg   <= 1'b1;
                    bt_reg    <= pend_t_reg;
                    bmask_reg <= mem_q;
                end
                else if (!out_of_map)
                begin
                    pend_reg   <= 1'b1;
                    pend_t_reg <= nt;
                    gx_reg     <= ngx;
                    gy_reg     <= ngy;
                    if (take_x)
                        tx_reg <= tx_reg + T_W'(dx_reg);
                    else
                        ty_reg <= ty_reg + T_W'(dy_reg);
                end
            end
            gdda_pkg::B_MULP:
                pdist_reg <= wd;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_blk_reg   <= blk_reg;
            res_bdist_reg <= wd;
            res_bmask_reg <= bmask_reg;
            res_prj_reg   <= prj_reg;
            res_pdist_reg <= pdist_reg;
        end
    end

    `GDDA_ASSERT_IMPL(a_no_pop_while_clearing, state_reg == gdda_pkg::B_CLEAR, !q_pop)
    `GDDA_ASSERT_NEXT(a_blocker_ends_walk, (state_reg == gdda_pkg::B_WALK) && hit_b,
                      (state_reg == gdda_pkg::B_MULP) && blk_reg)
    `GDDA_ASSERT_NEXT(a_result_waits, (state_reg == gdda_pkg::B_MULB) && out_valid_reg && !pop,
                      (state_reg == gdda_pkg::B_MULB) && out_valid_reg)

endmodule

`default_nettype wire

FILE: test/grid_dda_dual_hit_ray_caster_tb.sv
`default_nettype none

module grid_dda_dual_hit_ray_caster_tb;

    localparam int  MAP_W       = 64;
    localparam int  MAP_H       = 64;
    localparam int  RAND_ITEMS  = 1200;
    localparam int  DRAIN_WAIT  = 200;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam longint unsigned DELTA_INF = 64'd1 << 40;

    typedef struct {
        bit        blk;
        bit [23:0] bdist;
        bit [15:0] bmask;
        bit        prj;
        bit [23:0] pdist;
    } hit_t;

    typedef struct {
        bit        fn;
        bit [5:0]  cx;
        bit [5:0]  cy;
        bit [15:0] cmask;
        bit [15:0] sx;
        bit [15:0] sy;
        bit [15:0] ddx;
        bit [15:0] ddy;
        bit        typed;
        hit_t      res;
    } ray_req_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = gdda_pkg::CFG_BLOCKING_MASK;
    logic [15:0]         cfg_data = '0;
    logic                push = 1'b0;
    logic                full;
    logic                func = gdda_pkg::FUNC_WRITE;
    logic [5:0]          cell_x = '0;
    logic [5:0]          cell_y = '0;
    logic [15:0]         cell_mask = '0;
    logic [15:0]         start_x = '0;
    logic [15:0]         start_y = '0;
    logic signed [15:0]  dir_x = '0;
    logic signed [15:0]  dir_y = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic                blocker_found;
    logic [23:0]         blocker_dist;
    logic [15:0]         blocker_mask;
    logic                projectile_found;
    logic [23:0]         projectile_dist;

    grid_dda_dual_hit_ray_caster u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .func(func), .cell_x(cell_x), .cell_y(cell_y), .cell_mask(cell_mask),
        .start_x(start_x), .start_y(start_y), .dir_x(dir_x), .dir_y(dir_y),
        .empty(empty), .pop(pop),
        .blocker_found(blocker_found), .blocker_dist(blocker_dist),
        .blocker_mask(blocker_mask), .projectile_found(projectile_found),
        .projectile_dist(projectile_dist)
    );

    bit [15:0] grid_model [MAP_W*MAP_H];
    bit [15:0] blk_mask_m = 16'h0000;
    bit [15:0] prj_mask_m = 16'h0000;
    bit [9:0]  cell_size_m = gdda_pkg::CELL_SIZE_RESET;
    hit_t      hit_q[$];
    int        fail_cnt = 0;
    int        hit_cnt = 0;
    int        casts_sent = 0;
    int        writes_sent = 0;
    int        cycles = 0;
    int        hold_req = 0;
    bit        calm = 1'b0;
    ray_req_t  dir_rows[$];

    always #1 clk = ~clk;

    function automatic longint unsigned axis_step(bit [15:0] v, output bit neg);
        longint unsigned mag;
        neg = v[15];
        mag = neg ? (64'h10000 - v) : v;
        return (mag == 0) ? DELTA_INF : ((64'd1 << 30) / mag);
    endfunction

    function automatic bit [23:0] scale_dist(longint unsigned t);
        longint unsigned w;
        w = (t * cell_size_m) >> 8;
        return (w > 64'hFFFFFF) ? 24'hFFFFFF : w[23:0];
    endfunction

    function automatic hit_t trace_ray(bit [15:0] sx, bit [15:0] sy, bit [15:0] ddx,
                                       bit [15:0] ddy);
        hit_t r;
        bit nx, ny;
        longint unsigned stx, sty, tx, ty, t;
        int gx, gy;
        bit [15:0] m;
        r = '{default: 0};
        stx = axis_step(ddx, nx);
        sty = axis_step(ddy, ny);
        tx = ((nx ? sx[9:0] : 64'd1024 - sx[9:0]) * stx) >> 10;
        ty = ((ny ? sy[9:0] : 64'd1024 - sy[9:0]) * sty) >> 10;
        gx = int'(sx[15:10]);
        gy = int'(sy[15:10]);
        while (1)
        begin
            if (tx < ty)
            begin
                gx += nx ? -1 : 1;
                t = tx;
                tx += stx;
            end
            else
            begin
                gy += ny ? -1 : 1;
                t = ty;
                ty += sty;
            end
            if (gx < 0 || gx >= MAP_W || gy < 0 || gy >= MAP_H)
                break;
            m = grid_model[gy*MAP_W + gx];
            if (!r.prj && (m & prj_mask_m) != 0)
            begin
                r.prj = 1'b1;
                r.pdist = scale_dist(t);
            end
            if ((m & blk_mask_m) != 0)
            begin
                r.blk = 1'b1;
                r.bdist = scale_dist(t);
                r.bmask = m;
                break;
            end
        end
        return r;
    endfunction

    task automatic send_request(ray_req_t rq);
        while (!calm && $urandom_range(99) < 35)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        func      <= rq.fn;
        cell_x    <= rq.cx;
        cell_y    <= rq.cy;
        cell_mask <= rq.cmask;
        start_x   <= rq.sx;
        start_y   <= rq.sy;
        dir_x     <= rq.ddx;
        dir_y     <= rq.ddy;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (rq.fn == gdda_pkg::FUNC_WRITE)
        begin
            grid_model[rq.cy*MAP_W + rq.cx] = rq.cmask;
            writes_sent++;
        end
        else
        begin
            hit_q.push_back(rq.typed ? rq.res : trace_ray(rq.sx, rq.sy, rq.ddx, rq.ddy));
            casts_sent++;
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (hit_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, bit [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            gdda_pkg::CFG_BLOCKING_MASK:   blk_mask_m = val;
            gdda_pkg::CFG_PROJECTILE_MASK: prj_mask_m = val;
            gdda_pkg::CFG_CELL_SIZE:       cell_size_m = val[9:0];
            default: ;
        endcase
    endtask

    function automatic ray_req_t cell_write(int x, int y, bit [15:0] m);
        ray_req_t rq;
        rq = '{default: 0};
        rq.fn = gdda_pkg::FUNC_WRITE;
        rq.cx = 6'(x);
        rq.cy = 6'(y);
        rq.cmask = m;
        return rq;
    endfunction

    function automatic ray_req_t cast(bit [15:0] sx, bit [15:0] sy, int ddx, int ddy,
                                      bit typed_zero);
        ray_req_t rq;
        rq = '{default: 0};
        rq.fn = gdda_pkg::FUNC_CAST;
        rq.sx = sx;
        rq.sy = sy;
        rq.ddx = 16'(ddx);
        rq.ddy = 16'(ddy);
        rq.typed = typed_zero;
        return rq;
    endfunction

    function automatic bit [15:0] rand_dir();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return $urandom_range(1) ? 16'($urandom_range(15))
                                        : 16'(-$urandom_range(15, 1));
            default: return 16'($urandom_range(32768) - 16384);
        endcase
    endfunction

    function automatic ray_req_t rand_request();
        if ($urandom_range(99) < 40)
            return cell_write($urandom_range(63), $urandom_range(63),
                              $urandom_range(3) == 0 ? 16'h0
                                                     : 16'($urandom_range(16'hFFFF)));
        return cast(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                    $signed(rand_dir()), $signed(rand_dir()), 1'b0);
    endfunction

    // result checker and receiver idling
    int hold_cnt = 0;
    always @(posedge clk)
    begin
        hit_t e;
        if (pop && !empty)
        begin
            hit_cnt++;
            if (hit_q.size() == 0)
            begin
                $error("result with no request pending");
                fail_cnt++;
            end
            else
            begin
                e = hit_q.pop_front();
                if (blocker_found !== e.blk)
                begin
                    $error("blocker_found exp %0d got %0d", e.blk, blocker_found);
                    fail_cnt++;
                end
                if (blocker_dist !== e.bdist)
                begin
                    $error("blocker_dist exp %0h got %0h", e.bdist, blocker_dist);
                    fail_cnt++;
                end
                if (blocker_mask !== e.bmask)
                begin
                    $error("blocker_mask exp %0h got %0h", e.bmask, blocker_mask);
                    fail_cnt++;
                end
                if (projectile_found !== e.prj)
                begin
                    $error("projectile_found exp %0d got %0d", e.prj, projectile_found);
                    fail_cnt++;
                end
                if (projectile_dist !== e.pdist)
                begin
                    $error("projectile_dist exp %0h got %0h", e.pdist, projectile_dist);
                    fail_cnt++;
                end
            end
        end
        if (hold_req != 0)
        begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            pop <= 1'b0;
        end
        else
            pop <= calm || ($urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        bit [15:0] reg_sets [6][3];
        reg_sets = '{'{16'h0001, 16'h0002, 16'd32}, '{16'hFFFF, 16'hFFFF, 16'd1023},
                     '{16'h0000, 16'hFFFF, 16'd1},  '{16'h00F0, 16'h0F0F, 16'd511},
                     '{16'h8001, 16'h7FFE, 16'd64}, '{16'h5555, 16'hAAAA, 16'd1000}};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset config: nothing blocks, so these return all zeros
        dir_rows.push_back(cast(16'h0000, 16'h0000, 16384, 0, 1'b1));
        dir_rows.push_back(cast(16'hFFFF, 16'hFFFF, 0, 0, 1'b1));
        foreach (dir_rows[i])
            send_request(dir_rows[i]);
        drain_results();

        write_reg(gdda_pkg::CFG_BLOCKING_MASK, 16'h0001);
        write_reg(gdda_pkg::CFG_PROJECTILE_MASK, 16'h0002);
        write_reg(gdda_pkg::CFG_CELL_SIZE, 16'd32);
        dir_rows = {};
        dir_rows.push_back(cast(16'h0200, 16'h0200, 16384, 0, 1'b1));
        dir_rows.push_back(cell_write(5, 0, 16'h0001));
        dir_rows.push_back(cast(16'h0200, 16'h0200, 16384, 0, 1'b0));
        dir_rows.push_back(cell_write(2, 0, 16'h0002));
        dir_rows.push_back(cast(16'h0200, 16'h0200, 16384, 0, 1'b0));
        dir_rows.push_back(cell_write(0, 5, 16'h0003));
        dir_rows.push_back(cast(16'h0000, 16'h0000, 0, 16384, 1'b0));
        dir_rows.push_back(cell_write(63, 63, 16'hFFFF));
        dir_rows.push_back(cast(16'hF800, 16'hF900, 16384, 16384, 1'b0));
        dir_rows.push_back(cast(16'hFFFF, 16'hFFFF, 16384, 16384, 1'b1));
        // start cell is never tested
        dir_rows.push_back(cell_write(0, 0, 16'hFFFF));
        dir_rows.push_back(cast(16'h0000, 16'h0000, -16384, -16384, 1'b1));
        dir_rows.push_back(cast(16'h1FFF, 16'h03FF, -16384, 1, 1'b0));
        dir_rows.push_back(cast(16'h8000, 16'h8000, 1, -1, 1'b0));
        dir_rows.push_back(cast(16'hFFFF, 16'h0000, -16384, 16384, 1'b0));
        dir_rows.push_back(cell_write(5, 0, 16'h0000));
        dir_rows.push_back(cast(16'h0200, 16'h0200, 16384, 0, 1'b0));
        dir_rows.push_back(cast(16'h7C00, 16'h0000, 0, 16384, 1'b0));
        dir_rows.push_back(cast(16'h0000, 16'h0000, 0, 0, 1'b0));
        foreach (dir_rows[i])
            send_request(dir_rows[i]);
        drain_results();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(gdda_pkg::CFG_BLOCKING_MASK, reg_sets[ph][0]);
            write_reg(gdda_pkg::CFG_PROJECTILE_MASK, reg_sets[ph][1]);
            write_reg(gdda_pkg::CFG_CELL_SIZE, reg_sets[ph][2]);
            calm = (ph == 2);
            for (int n = 0; n < RAND_ITEMS / 6; n++)
            begin
                if (ph == 1 && n == 20)
                    hold_req = 600;
                send_request(rand_request());
            end
            drain_results();
        end
        calm = 1'b0;

        $display("%0d casts and %0d map writes over 8 register settings, %0d results checked",
                 casts_sent, writes_sent, hit_cnt);
        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
